// ===== src/llrb_pkg.sv =====
// llrb_pkg: shared types and constants of the last-lines ring buffer
// used by the top level under src and by the testbench; depends on nothing

package llrb_pkg;

    localparam int DEF_SLOTS      = 64;
    localparam int DEF_LINE_BYTES = 1024;
    localparam int TAIL_W         = 7;

    localparam logic [7:0]        NEWLINE    = 8'd10;
    localparam logic [TAIL_W-1:0] TAIL_RESET = 7'd10;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_PULL = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last;
    } t_out;

endpackage

// ===== src/last_lines_ring_buffer.sv =====
// last_lines_ring_buffer: top level, control sequencer and drain logic
// depends on llrb_pkg, llrb_byte_ram and llrb_len_ram
//
// usage:
//   command channel: a transaction is taken when start is high and busy low.
//   push (command 0) appends data_byte to the open line; a newline commits the
//   line into its ring slot. pull (command 1) returns the next byte of the kept
//   text, oldest line first. clear (command 2) empties the store.
//   result channel: o_strobe marks o_result for exactly one cycle; the
//   receiver cannot stall it.
//   config: i_cfg_we writes tail_lines from i_cfg_data and empties the store.
// timing:
//   push and clear give no result; busy stays low.
//   pull reads the byte and length memories when taken, forms the result in
//   the pull state and shows it on o_strobe the cycle after; busy is high in
//   the pull state, so a new pull is taken only once the last one is formed.
//   the open line is written straight into the slot it will commit to, so a
//   newline costs a single length write.
// reset: store empty, tail_lines 10, no drain in progress; no clearing pass.

module last_lines_ring_buffer #(
    parameter int SLOTS      = llrb_pkg::DEF_SLOTS,
    parameter int LINE_BYTES = llrb_pkg::DEF_LINE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  llrb_pkg::t_in                 i_item,
    output logic                          busy,
    output logic                          o_strobe,
    output llrb_pkg::t_out                o_result,
    input  logic                          i_cfg_we,
    input  logic [llrb_pkg::TAIL_W-1:0]   i_cfg_data
);

    localparam int SL_W   = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int POS_W  = $clog2(LINE_BYTES + 1);
    localparam int DEPTH  = SLOTS * LINE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > llrb_pkg::TAIL_W) ? CNT_W : llrb_pkg::TAIL_W;

    llrb_pkg::t_state r_state, n_state;

    logic [llrb_pkg::TAIL_W-1:0] r_tail;
    logic [POS_W-1:0]            r_plen, n_plen;
    logic [SL_W-1:0]             r_wslot, n_wslot;
    logic [CNT_W-1:0]            r_seen, n_seen;
    logic                        r_draining, n_draining;
    logic [CNT_W-1:0]            r_line, n_line;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [CNT_W-1:0]            r_shown, n_shown;
    logic                        r_strobe, n_strobe;
    llrb_pkg::t_out              r_result, n_result;

    logic             accept;
    logic             do_clear;
    logic             is_push;
    logic             is_nl;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] shown;
    logic [SUM_W-1:0] start_sum;
    logic [SL_W-1:0]  start_slot;
    logic [CNT_W-1:0] line0;
    logic [POS_W-1:0] pos0;
    logic [SUM_W-1:0] line_sum;
    logic [SL_W-1:0]  line_slot;
    logic [SL_W-1:0]  rd_slot;
    logic [POS_W-1:0] rd_pos;
    logic [SUM_W-1:0] wslot_inc;

    logic              byte_we;
    logic [ADDR_W-1:0] byte_waddr;
    logic [ADDR_W-1:0] byte_raddr;
    logic [7:0]        byte_rd;
    logic              len_we;
    logic [POS_W-1:0]  len_rd;

    // effective line count: tail_lines clamped to 1..SLOTS
    always_comb begin
        if (r_tail == '0) begin
            n_eff = CNT_W'(1);
        end else if (CMP_W'(r_tail) > CMP_W'(SLOTS)) begin
            n_eff = CNT_W'(SLOTS);
        end else begin
            n_eff = CNT_W'(r_tail);
        end
    end

    // an open partial line takes one of the n places
    assign room  = (r_plen != '0) ? n_eff - CNT_W'(1) : n_eff;
    assign shown = (r_seen < room) ? r_seen : room;

    assign start_sum  = SUM_W'(r_wslot) + SUM_W'(n_eff) - SUM_W'(shown);
    assign start_slot = (start_sum >= SUM_W'(n_eff)) ? SL_W'(start_sum - SUM_W'(n_eff))
                                                     : SL_W'(start_sum);

    // a new drain session starts at the oldest kept line
    assign line0 = r_draining ? r_line : '0;
    assign pos0  = r_draining ? r_pos  : '0;

    assign line_sum  = SUM_W'(start_slot) + SUM_W'(line0);
    assign line_slot = (line_sum >= SUM_W'(n_eff)) ? SL_W'(line_sum - SUM_W'(n_eff))
                                                   : SL_W'(line_sum);

    // partial line bytes live in the row of the current write slot
    assign rd_slot    = (line0 < shown) ? line_slot : r_wslot;
    assign rd_pos     = (pos0 < POS_W'(LINE_BYTES)) ? pos0 : '0;
    assign byte_raddr = ADDR_W'(rd_slot) * ADDR_W'(LINE_BYTES) + ADDR_W'(rd_pos);

    assign accept   = start && (r_state == llrb_pkg::ST_IDLE);
    assign is_push  = accept && (i_item.command == llrb_pkg::CMD_PUSH);
    assign is_nl    = (i_item.data_byte == llrb_pkg::NEWLINE);
    assign do_clear = i_cfg_we || (accept && (i_item.command == llrb_pkg::CMD_CLEAR));

    assign byte_we    = is_push && !is_nl && (r_plen < POS_W'(LINE_BYTES));
    assign byte_waddr = ADDR_W'(r_wslot) * ADDR_W'(LINE_BYTES) + ADDR_W'(r_plen);
    assign len_we     = is_push && is_nl;
    assign wslot_inc  = SUM_W'(r_wslot) + SUM_W'(1);

    llrb_byte_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (i_item.data_byte),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rd)
    );

    llrb_len_ram #(
        .SLOTS (SLOTS),
        .LEN_W (POS_W),
        .SL_W  (SL_W)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (do_clear),
        .i_we    (len_we),
        .i_waddr (r_wslot),
        .i_wdata (r_plen),
        .i_raddr (line_slot),
        .o_rdata (len_rd)
    );

    // next state and busy
    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        case (r_state)
            llrb_pkg::ST_IDLE: begin
                if (accept && (i_item.command == llrb_pkg::CMD_PULL)) begin
                    n_state = llrb_pkg::ST_PULL;
                end
            end
            llrb_pkg::ST_PULL: begin
                busy    = 1'b1;
                n_state = llrb_pkg::ST_IDLE;
            end
            default: begin
                n_state = llrb_pkg::ST_IDLE;
            end
        endcase
    end

    // store bookkeeping and drain datapath
    always_comb begin
        n_plen     = r_plen;
        n_wslot    = r_wslot;
        n_seen     = r_seen;
        n_draining = r_draining;
        n_line     = r_line;
        n_pos      = r_pos;
        n_shown    = r_shown;
        n_strobe   = 1'b0;
        n_result   = r_result;

        if (do_clear) begin
            n_plen     = '0;
            n_wslot    = '0;
            n_seen     = '0;
            n_draining = 1'b0;
        end else if (is_push) begin
            n_draining = 1'b0;
            if (is_nl) begin
                n_plen  = '0;
                n_wslot = (wslot_inc >= SUM_W'(n_eff)) ? '0 : SL_W'(wslot_inc);
                if (r_seen < CNT_W'(SLOTS)) begin
                    n_seen = r_seen + CNT_W'(1);
                end
            end else if (r_plen < POS_W'(LINE_BYTES)) begin
                n_plen = r_plen + POS_W'(1);
            end
        end else if (accept && (i_item.command == llrb_pkg::CMD_PULL)) begin
            n_draining = 1'b1;
            n_line     = line0;
            n_pos      = pos0;
            n_shown    = shown;
        end

        if (r_state == llrb_pkg::ST_PULL) begin
            n_strobe           = 1'b1;
            n_result.out_byte  = '0;
            n_result.out_valid = 1'b0;
            if (r_line < r_shown) begin
                n_result.out_valid = 1'b1;
                if (r_pos < len_rd) begin
                    n_result.out_byte = byte_rd;
                    n_pos             = r_pos + POS_W'(1);
                end else begin
                    n_result.out_byte = llrb_pkg::NEWLINE;
                    n_line            = r_line + CNT_W'(1);
                    n_pos             = '0;
                end
            end else if ((r_line == r_shown) && (r_pos < r_plen)) begin
                n_result.out_valid = 1'b1;
                n_result.out_byte  = byte_rd;
                n_pos              = r_pos + POS_W'(1);
            end
            // last when the result is empty or nothing remains after this byte
            n_result.last = !n_result.out_valid ||
                            !((n_line < r_shown) ||
                              ((n_line == r_shown) && (n_pos < r_plen)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llrb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail     <= llrb_pkg::TAIL_RESET;
            r_plen     <= '0;
            r_wslot    <= '0;
            r_seen     <= '0;
            r_draining <= 1'b0;
            r_line     <= '0;
            r_pos      <= '0;
            r_shown    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tail <= i_cfg_data;
            end
            r_plen     <= n_plen;
            r_wslot    <= n_wslot;
            r_seen     <= n_seen;
            r_draining <= n_draining;
            r_line     <= n_line;
            r_pos      <= n_pos;
            r_shown    <= n_shown;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a result only follows the pull state of a pull transaction
    a_strobe_after_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a pull in progress");

    // the pull sequencer holds busy for a single cycle
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // an empty result is zero and flagged last
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.out_valid) |-> (o_result.last && (o_result.out_byte == '0)))
        else $error("empty result not marked last");

    // the open line never outgrows a slot row
    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= POS_W'(LINE_BYTES))
        else $error("partial line length beyond slot size");

endmodule

// ===== src/llrb_byte_ram.sv =====
// llrb_byte_ram: byte store for all line slots, one row of LINE_BYTES per slot
// one write port, one read port with registered data; no package dependency

module llrb_byte_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/llrb_len_ram.sv =====
// llrb_len_ram: length of the committed line in each slot
// registered read; per-slot valid bits make a cleared slot read as zero

module llrb_len_ram #(
    parameter int SLOTS = 64,
    parameter int LEN_W = 11,
    parameter int SL_W  = $clog2(SLOTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_we,
    input  logic [SL_W-1:0]  i_waddr,
    input  logic [LEN_W-1:0] i_wdata,
    input  logic [SL_W-1:0]  i_raddr,
    output logic [LEN_W-1:0] o_rdata
);

    logic [LEN_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [LEN_W-1:0] r_rdata;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

// ===== tb/sv/llrb_tail_checker.sv =====
// llrb_tail_checker: predicts the pull results of the last-lines ring buffer
// and compares them with the result channel; depends on llrb_pkg

module llrb_tail_checker
    import llrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  t_in               i_item,
    input  logic              o_strobe,
    input  t_out              o_result,
    input  logic              i_cfg_we,
    input  logic [TAIL_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = DEF_SLOTS;
    localparam int LINE_BYTES = DEF_LINE_BYTES;

    logic [7:0]        line_mem [0:SLOTS*LINE_BYTES-1];
    int unsigned       line_len [SLOTS];
    logic [7:0]        part_mem [LINE_BYTES];
    int unsigned       part_len;
    int unsigned       wr_slot;
    int unsigned       lines_held;
    int unsigned       drain_ln;
    int unsigned       drain_pos;
    bit                in_drain;
    logic [TAIL_W-1:0] tail_reg;
    t_out              tail_bytes_due [$];
    int                fails;

    function automatic int unsigned tail_count();
        if (tail_reg == 0) return 1;
        if (tail_reg > SLOTS) return SLOTS;
        return tail_reg;
    endfunction

    function automatic void tail_clear();
        for (int s = 0; s < SLOTS; s++) line_len[s] = 0;
        part_len   = 0;
        wr_slot    = 0;
        lines_held = 0;
        in_drain   = 0;
        drain_ln   = 0;
        drain_pos  = 0;
    endfunction

    function automatic void tail_push(logic [7:0] b);
        int unsigned n;
        int unsigned slot;
        n        = tail_count();
        in_drain = 0;
        if (b == NEWLINE) begin
            slot = wr_slot % n;
            for (int i = 0; i < part_len; i++) line_mem[slot*LINE_BYTES + i] = part_mem[i];
            line_len[slot] = part_len;
            wr_slot        = (slot + 1 >= n) ? 0 : slot + 1;
            if (lines_held < SLOTS) lines_held++;
            part_len = 0;
        end else if (part_len < LINE_BYTES) begin
            // bytes past the slot size are dropped
            part_mem[part_len] = b;
            part_len++;
        end
    endfunction

    function automatic t_out tail_next_byte();
        int unsigned n;
        int unsigned room;
        int unsigned shown;
        int unsigned oldest;
        int unsigned slot;
        logic [7:0]  b;
        bit          valid;
        bit          more;
        t_out        r;
        n      = tail_count();
        // an open partial line takes one of the n places
        room   = (part_len > 0) ? n - 1 : n;
        shown  = (lines_held < room) ? lines_held : room;
        oldest = ((wr_slot % n) + n - shown) % n;
        b      = 8'h00;
        valid  = 0;
        if (!in_drain) begin
            in_drain  = 1;
            drain_ln  = 0;
            drain_pos = 0;
        end
        if (drain_ln < shown) begin
            slot  = (oldest + drain_ln) % n;
            valid = 1;
            if (drain_pos < line_len[slot]) begin
                b = line_mem[slot*LINE_BYTES + drain_pos];
                drain_pos++;
            end else begin
                b = NEWLINE;
                drain_ln++;
                drain_pos = 0;
            end
        end else if (drain_ln == shown && drain_pos < part_len) begin
            b     = part_mem[drain_pos];
            valid = 1;
            drain_pos++;
        end
        more = (drain_ln < shown) || (drain_ln == shown && drain_pos < part_len);
        r.out_byte  = valid ? b : 8'h00;
        r.out_valid = valid;
        r.last      = !valid || !more;
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fails++;
        if (fails <= 10) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : check_proc
        t_out due;
        if (!i_rst_n) begin
            tail_reg = TAIL_RESET;
            tail_clear();
            tail_bytes_due.delete();
        end else begin
            // compare before predicting so a result never meets its own transaction
            if (o_strobe) begin
                if (tail_bytes_due.size() == 0) begin
                    note_failure($sformatf("unexpected result: byte %02h valid %0b last %0b",
                        o_result.out_byte, o_result.out_valid, o_result.last));
                end else begin
                    due = tail_bytes_due.pop_front();
                    if (due.out_byte !== o_result.out_byte ||
                        due.out_valid !== o_result.out_valid ||
                        due.last !== o_result.last) begin
                        note_failure($sformatf(
                            "mismatch: expected byte %02h valid %0b last %0b, got byte %02h valid %0b last %0b",
                            due.out_byte, due.out_valid, due.last,
                            o_result.out_byte, o_result.out_valid, o_result.last));
                    end
                end
            end
            if (i_cfg_we) begin
                tail_reg = i_cfg_data;
                tail_clear();
            end
            if (start && !busy) begin
                case (i_item.command)
                    CMD_PUSH:  tail_push(i_item.data_byte);
                    CMD_PULL:  tail_bytes_due.push_back(tail_next_byte());
                    CMD_CLEAR: tail_clear();
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= tail_bytes_due.size();
    end

endmodule

// ===== tb/sv/tb_last_lines_ring_buffer.sv =====
// tb_last_lines_ring_buffer: stimulus and verdict for last_lines_ring_buffer
// depends on llrb_pkg, the block under src and llrb_tail_checker

module tb_last_lines_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;
    import llrb_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASES       = 6;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              start    = 1'b0;
    t_in               i_item   = '0;
    logic              i_cfg_we = 1'b0;
    logic [TAIL_W-1:0] i_cfg_data = '0;
    logic              busy;
    logic              o_strobe;
    t_out              o_result;
    int                fail_count;
    int                pending;
    int                sent_items = 0;
    int                idle_pct   = 0;

    always #4 i_clk = ~i_clk;

    last_lines_ring_buffer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    llrb_tail_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_strobe     (o_strobe),
        .o_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // returns at the edge that accepts the transaction, start still high
    task automatic send(t_cmd c, logic [7:0] d);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{command: c, data_byte: d};
        do @(posedge i_clk); while (busy);
        if (c == CMD_PUSH || c == CMD_PULL || c == CMD_CLEAR) sent_items++;
    endtask

    task automatic push_line(int len, bit terminate);
        logic [7:0] b;
        repeat (len) begin
            do b = 8'($urandom_range(0, 255)); while (b == NEWLINE);
            send(CMD_PUSH, b);
        end
        if (terminate) send(CMD_PUSH, NEWLINE);
    endtask

    // pull until the block marks the final byte
    task automatic drain_tail();
        bit done;
        done = 1'b0;
        while (!done) begin
            send(CMD_PULL, 8'($urandom_range(0, 255)));
            start <= 1'b0;
            do @(posedge i_clk); while (!o_strobe);
            done = o_result.last;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_tail(logic [TAIL_W-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int                phase;
        int                base;
        int                phase_end;
        int                fill;
        int                roll;
        int                len;
        logic [TAIL_W-1:0] tails [PHASES];
        tails = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd10, 7'd2};
        tails[4] = TAIL_W'($urandom_range(1, 64));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset setting of ten lines
        send(CMD_PULL, 8'h00);
        send(CMD_PUSH, 8'hFF);
        send(CMD_PUSH, 8'h00);
        send(CMD_PUSH, NEWLINE);
        send(CMD_PUSH, 8'h41);
        repeat (5) send(CMD_PULL, 8'hFF);
        send(t_cmd'(2'd3), 8'hA5);
        send(CMD_PUSH, NEWLINE);
        send(CMD_PUSH, NEWLINE);
        repeat (2) send(CMD_PULL, 8'h00);
        send(CMD_PUSH, 8'h7E);
        repeat (3) send(CMD_PULL, 8'h00);
        send(CMD_CLEAR, 8'h5A);
        send(CMD_PULL, 8'h00);

        base = sent_items;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                1: idle_pct = 65;
                3: idle_pct = 20;
                default: idle_pct = 0;
            endcase
            set_tail(tails[phase]);
            fill = (tails[phase] == 0) ? 1 : (tails[phase] > DEF_SLOTS ? DEF_SLOTS : tails[phase]);
            // enough short lines to wrap the ring and saturate the line count
            repeat (fill + 3) push_line($urandom_range(0, 2), 1'b1);
            drain_tail();
            phase_end = base + ((phase + 1) * RANDOM_ITEMS) / PHASES;
            while (sent_items < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                    push_line(len, $urandom_range(0, 99) < 85);
                end else if (roll < 80) begin
                    drain_tail();
                    repeat ($urandom_range(0, 2)) send(CMD_PULL, 8'($urandom_range(0, 255)));
                end else if (roll < 90) begin
                    // drain cut short, the next push closes it
                    repeat ($urandom_range(1, 5)) send(CMD_PULL, 8'($urandom_range(0, 255)));
                end else if (roll < 95) begin
                    send(CMD_CLEAR, 8'($urandom_range(0, 255)));
                end else if (roll < 97) begin
                    send(t_cmd'(2'd3), 8'($urandom_range(0, 255)));
                end else begin
                    send(CMD_PUSH, 8'($urandom_range(0, 255)));
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("last_lines_ring_buffer test passed");
        end else begin
            $display("last_lines_ring_buffer test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("last_lines_ring_buffer test failed");
        $finish;
    end

endmodule
